FILE: src/tlpfk_pkg.sv
// shared types, constants and helper functions for the two-link arm kinematics block
package tlpfk_pkg;

    localparam int CONST_FRAC = 30;
    localparam int TABLE_LEN  = 24;
    localparam int XW         = 32;
    localparam int LEN_W      = 16;
    localparam int POS_W      = 24;
    localparam int ANG_IN_W   = 16;
    localparam int PROD_W     = 49;
    localparam int TERM_W     = 19;
    localparam int SUM_W      = 26;
    localparam int REG_IDX_W  = 2;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint GAIN_Q30    = 64'sd652032874;

    localparam longint ATAN_Q30 [TABLE_LEN] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128
    };

    localparam logic [REG_IDX_W-1:0] REG_UPPER_LEN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOWER_LEN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_X    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BASE_Y    = 2'd3;

    typedef logic signed [XW-1:0]     trig_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic [LEN_W-1:0]         len_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] neg;
    } cell_ctl_t;

    // round half up from 30 fraction bits to ab fraction bits
    function automatic longint to_angle(longint q30, int ab);
        int sh;
        sh = CONST_FRAC - ab;
        return (q30 + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic pos_t sat_pos(logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'sd1 <<< (POS_W - 1)) - 1);
        lo = -SUM_W'(64'sd1 <<< (POS_W - 1));
        if (v > hi) begin
            return pos_t'(hi);
        end else if (v < lo) begin
            return pos_t'(lo);
        end
        return v[POS_W-1:0];
    endfunction

endpackage

FILE: src/tlpfk_reduce.sv
// angle scaling, whole-turn reduction and half-turn fold for the shoulder angle and the shoulder-plus-elbow sum
module tlpfk_reduce #(
    parameter int ANGLE_BITS = 16,
    parameter int AW         = 21
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     en,
    input  logic                                     in_valid,
    input  logic signed [tlpfk_pkg::ANG_IN_W-1:0]    shoulder,
    input  logic signed [tlpfk_pkg::ANG_IN_W-1:0]    elbow,
    output tlpfk_pkg::cell_ctl_t                     out_ctl,
    output tlpfk_pkg::trig_t                         out_x [2],
    output tlpfk_pkg::trig_t                         out_y [2],
    output logic signed [AW-1:0]                     out_z [2]
);
    import tlpfk_pkg::*;

    localparam logic signed [AW-1:0] PI_A = AW'(to_angle(PI_Q30, ANGLE_BITS));
    localparam logic signed [AW-1:0] HP_A = AW'(to_angle(HALF_PI_Q30, ANGLE_BITS));
    localparam logic signed [AW-1:0] TP_A = AW'(to_angle(TWO_PI_Q30, ANGLE_BITS));

    logic                    valid_reg;
    logic [1:0]              neg_reg;
    logic [1:0]              neg_next;
    logic signed [AW-1:0]    z_reg  [2];
    logic signed [AW-1:0]    z_next [2];
    logic signed [ANG_IN_W:0] ang_sum;

    always_comb begin
        logic signed [AW-1:0] a;
        ang_sum = {shoulder[ANG_IN_W-1], shoulder} + {elbow[ANG_IN_W-1], elbow};
        for (int l = 0; l < 2; l++) begin
            if (l == 0) begin
                a = AW'(shoulder) <<< (ANGLE_BITS - 12);
            end else begin
                a = AW'(ang_sum) <<< (ANGLE_BITS - 12);
            end
            for (int k = 0; k < 4; k++) begin
                if (a > PI_A) begin
                    a = a - TP_A;
                end else if (a < -PI_A) begin
                    a = a + TP_A;
                end
            end
            neg_next[l] = 1'b0;
            if (a > HP_A) begin
                a = a - PI_A;
                neg_next[l] = 1'b1;
            end else if (a < -HP_A) begin
                a = a + PI_A;
                neg_next[l] = 1'b1;
            end
            z_next[l] = a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg  <= neg_next;
            z_reg[0] <= z_next[0];
            z_reg[1] <= z_next[1];
        end
    end

    assign out_ctl.valid = valid_reg;
    assign out_ctl.neg   = neg_reg;
    assign out_x[0] = trig_t'(GAIN_Q30);
    assign out_x[1] = trig_t'(GAIN_Q30);
    assign out_y[0] = '0;
    assign out_y[1] = '0;
    assign out_z    = z_reg;

endmodule

FILE: src/tlpfk_cordic_cell.sv
// one rotation step of the cordic chain, two lanes side by side
module tlpfk_cordic_cell #(
    parameter int ANGLE_BITS = 16,
    parameter int AW         = 21,
    parameter int STEP       = 0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  tlpfk_pkg::cell_ctl_t      in_ctl,
    input  tlpfk_pkg::trig_t          in_x [2],
    input  tlpfk_pkg::trig_t          in_y [2],
    input  logic signed [AW-1:0]      in_z [2],
    output tlpfk_pkg::cell_ctl_t      out_ctl,
    output tlpfk_pkg::trig_t          out_x [2],
    output tlpfk_pkg::trig_t          out_y [2],
    output logic signed [AW-1:0]      out_z [2]
);
    import tlpfk_pkg::*;

    localparam logic signed [AW-1:0] ATAN_A = AW'(to_angle(ATAN_Q30[STEP], ANGLE_BITS));

    logic                 valid_reg;
    logic [1:0]           neg_reg;
    trig_t                x_reg  [2];
    trig_t                y_reg  [2];
    logic signed [AW-1:0] z_reg  [2];
    trig_t                x_next [2];
    trig_t                y_next [2];
    logic signed [AW-1:0] z_next [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (!in_z[l][AW-1]) begin
                x_next[l] = in_x[l] - (in_y[l] >>> STEP);
                y_next[l] = in_y[l] + (in_x[l] >>> STEP);
                z_next[l] = in_z[l] - ATAN_A;
            end else begin
                x_next[l] = in_x[l] + (in_y[l] >>> STEP);
                y_next[l] = in_y[l] - (in_x[l] >>> STEP);
                z_next[l] = in_z[l] + ATAN_A;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg <= in_ctl.neg;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
        end
    end

    assign out_ctl.valid = valid_reg;
    assign out_ctl.neg   = neg_reg;
    assign out_x = x_reg;
    assign out_y = y_reg;
    assign out_z = z_reg;

endmodule

FILE: src/tlpfk_scale.sv
// sign restore and link-length scaling of the four trig terms
module tlpfk_scale (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  tlpfk_pkg::cell_ctl_t  in_ctl,
    input  tlpfk_pkg::trig_t      in_x [2],
    input  tlpfk_pkg::trig_t      in_y [2],
    input  tlpfk_pkg::len_t       upper_len,
    input  tlpfk_pkg::len_t       lower_len,
    output logic                  out_valid,
    output tlpfk_pkg::term_t      out_term [4]
);
    import tlpfk_pkg::*;

    logic  valid_reg;
    term_t term_reg  [4];
    term_t term_next [4];

    always_comb begin
        trig_t                    c;
        logic signed [LEN_W:0]    len_s;
        logic signed [PROD_W-1:0] p;
        for (int k = 0; k < 4; k++) begin
            c = (k % 2 == 0) ? in_x[k / 2] : in_y[k / 2];
            if (in_ctl.neg[k / 2]) begin
                c = -c;
            end
            len_s = (k < 2) ? {1'b0, upper_len} : {1'b0, lower_len};
            p = PROD_W'(len_s) * PROD_W'(c);
            p = p + (PROD_W'(1) <<< (CONST_FRAC - 1));
            term_next[k] = p[PROD_W-1:CONST_FRAC];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            term_reg <= term_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_term  = term_reg;

endmodule

FILE: src/two_link_planar_forward_kinematics.sv
// top level: two-link planar arm forward kinematics, one angle pair per transaction
// path: reduce register, the chain of cordic cells, scale register, then the output register
// throughput: one transaction per cycle while the output is not stalled, set by the unrolled chain of cordic cells
// the whole chain advances when the output register is empty or taken
// reset: synchronous active-low aresetn clears all valid bits, link lengths return
// to 1.0 and base position to the origin
module two_link_planar_forward_kinematics #(
    parameter int ROTATION_STEPS = 16,
    parameter int ANGLE_BITS     = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tlpfk_pkg::REG_IDX_W-1:0]     cfg_addr,
    input  logic [tlpfk_pkg::POS_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // shoulder_angle [15:0], elbow_angle [31:16]
    input  logic [31:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // elbow_x [23:0], elbow_y [47:24], tool_x [71:48], tool_y [95:72]
    output logic [95:0]                         m_tdata
);
    import tlpfk_pkg::*;

    localparam int AW = ANGLE_BITS + 5;
    localparam int N  = ROTATION_STEPS;

    logic  en;
    len_t  upper_len_reg;
    len_t  lower_len_reg;
    pos_t  base_x_reg;
    pos_t  base_y_reg;

    cell_ctl_t            ctl [N+1];
    trig_t                cx  [N+1][2];
    trig_t                cy  [N+1][2];
    logic signed [AW-1:0] cz  [N+1][2];

    logic  scale_valid;
    term_t term [4];

    logic                    m_valid_reg;
    logic [95:0]             m_data_reg;
    logic signed [SUM_W-1:0] ex;
    logic signed [SUM_W-1:0] ey;
    logic signed [SUM_W-1:0] tx;
    logic signed [SUM_W-1:0] ty;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_len_reg <= LEN_W'(256);
            lower_len_reg <= LEN_W'(256);
            base_x_reg    <= '0;
            base_y_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_UPPER_LEN: upper_len_reg <= cfg_wdata[LEN_W-1:0];
                REG_LOWER_LEN: lower_len_reg <= cfg_wdata[LEN_W-1:0];
                REG_BASE_X:    base_x_reg    <= cfg_wdata;
                REG_BASE_Y:    base_y_reg    <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    tlpfk_reduce #(
        .ANGLE_BITS (ANGLE_BITS),
        .AW         (AW)
    ) u_reduce (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .shoulder (s_tdata[15:0]),
        .elbow    (s_tdata[31:16]),
        .out_ctl  (ctl[0]),
        .out_x    (cx[0]),
        .out_y    (cy[0]),
        .out_z    (cz[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        tlpfk_cordic_cell #(
            .ANGLE_BITS (ANGLE_BITS),
            .AW         (AW),
            .STEP       (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_ctl  (ctl[g]),
            .in_x    (cx[g]),
            .in_y    (cy[g]),
            .in_z    (cz[g]),
            .out_ctl (ctl[g+1]),
            .out_x   (cx[g+1]),
            .out_y   (cy[g+1]),
            .out_z   (cz[g+1])
        );
    end

    tlpfk_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_ctl    (ctl[N]),
        .in_x      (cx[N]),
        .in_y      (cy[N]),
        .upper_len (upper_len_reg),
        .lower_len (lower_len_reg),
        .out_valid (scale_valid),
        .out_term  (term)
    );

    always_comb begin
        ex = SUM_W'(base_x_reg) + SUM_W'(term[0]);
        ey = SUM_W'(base_y_reg) + SUM_W'(term[1]);
        tx = ex + SUM_W'(term[2]);
        ty = ey + SUM_W'(term[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= scale_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {sat_pos(ty), sat_pos(tx), sat_pos(ey), sat_pos(ex)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: src/tlpfk_checker.sv
// port-level checks for the kinematics block, bound to the top level
module tlpfk_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output transaction changed");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_flow_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is taken");

endmodule

bind two_link_planar_forward_kinematics tlpfk_checker u_tlpfk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/tb_top.sv
// testbench for the two-link planar arm forward kinematics block
`timescale 1ns / 1ps

module tb_top;
    import tlpfk_pkg::*;

    localparam int STEPS    = 16;
    localparam int ABITS    = 16;
    localparam int LATENCY  = STEPS + 3;
    localparam int WD_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [23:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;

    typedef struct packed {
        logic [23:0] tool_y;
        logic [23:0] tool_x;
        logic [23:0] elbow_y;
        logic [23:0] elbow_x;
    } arm_pose_t;

    two_link_planar_forward_kinematics #(
        .ROTATION_STEPS(STEPS),
        .ANGLE_BITS(ABITS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    longint     upper_len;
    longint     lower_len;
    longint     org_x;
    longint     org_y;
    arm_pose_t  pose_q[$];
    int         errors;
    int         sent;
    int         received;
    int         idle_cycles;
    int         sink_gap_mode;
    bit         sink_hold;
    bit         timed_out;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint angle_const(longint q30);
        return floor_shift(q30 + (64'sd1 <<< (29 - ABITS)), 30 - ABITS);
    endfunction

    task automatic sin_cos(input longint ang, output longint c, output longint s);
        longint pi_a;
        longint hp_a;
        longint tp_a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        pi_a = angle_const(PI_Q30);
        hp_a = angle_const(HALF_PI_Q30);
        tp_a = angle_const(TWO_PI_Q30);
        flip = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (ang > pi_a) begin
                ang -= tp_a;
            end else if (ang < -pi_a) begin
                ang += tp_a;
            end
        end
        if (ang > hp_a) begin
            ang -= pi_a;
            flip = 1'b1;
        end else if (ang < -hp_a) begin
            ang += pi_a;
            flip = 1'b1;
        end
        x = GAIN_Q30;
        y = 0;
        z = ang;
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= angle_const(ATAN_Q30[i]);
            end else begin
                x += dx;
                y -= dy;
                z += angle_const(ATAN_Q30[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint link_term(longint len, longint trig);
        return floor_shift(len * trig + (64'sd1 <<< 29), 30);
    endfunction

    function automatic logic [23:0] clamp_pos(longint v);
        if (v > 8388607) begin
            return 24'h7fffff;
        end else if (v < -8388608) begin
            return 24'h800000;
        end
        return v[23:0];
    endfunction

    task automatic predict_pose(input logic signed [15:0] sh, input logic signed [15:0] el);
        longint    c1;
        longint    n1;
        longint    c12;
        longint    n12;
        longint    ex;
        longint    ey;
        arm_pose_t p;
        sin_cos(longint'(sh) <<< (ABITS - 12), c1, n1);
        sin_cos((longint'(sh) + longint'(el)) <<< (ABITS - 12), c12, n12);
        ex = org_x + link_term(upper_len, c1);
        ey = org_y + link_term(upper_len, n1);
        p.elbow_x = clamp_pos(ex);
        p.elbow_y = clamp_pos(ey);
        p.tool_x  = clamp_pos(ex + link_term(lower_len, c12));
        p.tool_y  = clamp_pos(ey + link_term(lower_len, n12));
        pose_q.insert(pose_q.size(), p);
    endtask

    task automatic random_gap(input int mode);
        int n;
        n = 0;
        if (mode != 0) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 1) == 0) begin
                n = 0;
            end
        end
        if (n != 0) begin
            s_tvalid <= 1'b0;
        end
        repeat (n) @(negedge aclk);
    endtask

    // one input transaction, valid held until accepted
    task automatic send_angles(input logic [15:0] sh, input logic [15:0] el, input int gaps);
        random_gap(gaps);
        s_tdata  <= {el, sh};
        s_tvalid <= 1'b1;
        predict_pose(sh, el);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_UPPER_LEN: upper_len = val[15:0];
            REG_LOWER_LEN: lower_len = val[15:0];
            REG_BASE_X:    org_x = longint'(signed'(val));
            default:       org_y = longint'(signed'(val));
        endcase
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pose_q.size() != 0 && !timed_out) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic set_arm(input logic [15:0] l1, input logic [15:0] l2,
                           input logic [23:0] bx, input logic [23:0] by);
        drain();
        write_reg(REG_UPPER_LEN, {8'h00, l1});
        write_reg(REG_LOWER_LEN, {8'h00, l2});
        write_reg(REG_BASE_X, bx);
        write_reg(REG_BASE_Y, by);
    endtask

    task automatic test_reset_values;
        send_angles(16'h0000, 16'h0000, 0);
        send_angles(16'h1922, 16'h0000, 0);
        send_angles(16'h3244, 16'hcdbc, 0);
    endtask

    task automatic test_angle_extremes;
        logic [15:0] pts[12];
        pts = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h1922,
                16'he6de, 16'h3244, 16'hcdbc, 16'h1923, 16'h6488, 16'h9b78};
        for (int i = 0; i < 12; i++) begin
            send_angles(pts[i], pts[(i * 5 + 3) % 12], 0);
        end
        send_angles(16'h7fff, 16'h7fff, 0);
        send_angles(16'h8000, 16'h8000, 0);
    endtask

    task automatic test_saturation;
        set_arm(16'hffff, 16'hffff, 24'h7fffff, 24'h800000);
        send_angles(16'h0000, 16'h0000, 0);
        send_angles(16'h3244, 16'h0000, 0);
        send_angles(16'h1922, 16'h0000, 0);
        send_angles(16'he6de, 16'h0000, 0);
        set_arm(16'hffff, 16'h0000, 24'h800000, 24'h7fffff);
        send_angles(16'h3244, 16'h0000, 0);
        send_angles(16'h1922, 16'h3244, 0);
        set_arm(16'h0000, 16'hffff, 24'h000000, 24'h000000);
        send_angles(16'h0c91, 16'hf36f, 0);
    endtask

    task automatic test_random_stream;
        for (int phase = 0; phase < 6; phase++) begin
            set_arm($urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2048)),
                    $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2048)),
                    $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 8191) - 4096),
                    $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 8191) - 4096));
            sink_gap_mode = phase % 3;
            for (int i = 0; i < 230; i++) begin
                send_angles(16'($urandom), 16'($urandom), (phase % 2) ? 1 : (i / 60) % 2);
            end
        end
    endtask

    task automatic test_backpressure;
        drain();
        sink_hold = 1'b1;
        fork
            begin
                repeat (200) @(negedge aclk);
                sink_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++) begin
                    send_angles(16'($urandom), 16'($urandom), 0);
                end
            end
        join
    endtask

    // result sink: random or forced stalls, in-order compare
    always @(negedge aclk) begin
        if (sink_hold) begin
            m_tready <= 1'b0;
        end else if (sink_gap_mode == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        arm_pose_t got;
        arm_pose_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            received++;
            if (pose_q.size() == 0) begin
                $error("unexpected transaction: %h", m_tdata);
                errors++;
            end else begin
                want = pose_q.pop_front();
                if (got.elbow_x !== want.elbow_x) begin
                    $error("elbow_x expected %h actual %h", want.elbow_x, got.elbow_x);
                    errors++;
                end
                if (got.elbow_y !== want.elbow_y) begin
                    $error("elbow_y expected %h actual %h", want.elbow_y, got.elbow_y);
                    errors++;
                end
                if (got.tool_x !== want.tool_x) begin
                    $error("tool_x expected %h actual %h", want.tool_x, got.tool_x);
                    errors++;
                end
                if (got.tool_y !== want.tool_y) begin
                    $error("tool_y expected %h actual %h", want.tool_y, got.tool_y);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WD_LIMIT) begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        sink_hold     = 1'b0;
        sink_gap_mode = 1;
        timed_out     = 1'b0;
        errors        = 0;
        sent          = 0;
        received      = 0;
        idle_cycles   = 0;
        upper_len     = 256;
        lower_len     = 256;
        org_x         = 0;
        org_y         = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_reset_values();
        test_angle_extremes();
        test_saturation();
        test_random_stream();
        test_backpressure();
        set_arm(16'h0100, 16'h0100, 24'h000000, 24'h000000);
        drain();
        $display("covered %0d angle pairs, %0d poses checked, across link and base settings",
                 sent, received);
        $display("including full-range angles, position clamping and output stalls");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
